FILE: hdl/text_line_normalizer_top_defines.svh
// Assertion shorthands shared by the checkers of this block.
// Each expects clk and rst in the scope where it is used.
`ifndef TEXT_LINE_NORMALIZER_TOP_DEFINES_SVH
`define TEXT_LINE_NORMALIZER_TOP_DEFINES_SVH

// same-cycle implication, quiet while reset is high
`define TLN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while reset is high
`define TLN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that is also checked while reset is high
`define TLN_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/tln_pkg.sv
package tln_pkg;

  // character codes the line logic reacts to
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_FIRST_PRINT = 8'd32;

  // tab stop limits
  localparam logic [6:0] TAB_MIN = 7'd1;
  localparam logic [6:0] TAB_MAX = 7'd80;

  // control byte handling modes (the unused code behaves as keep)
  localparam logic [1:0] CTRL_KEEP    = 2'd0;
  localparam logic [1:0] CTRL_REPLACE = 2'd1;
  localparam logic [1:0] CTRL_DROP    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_TAB_SIZE    = 2'd0;
  localparam logic [1:0] REG_EXPAND_TABS = 2'd1;
  localparam logic [1:0] REG_CTRL_MODE   = 2'd2;
  localparam logic [1:0] REG_SUBST_CHAR  = 2'd3;

  // reset values of the configuration registers
  localparam logic [6:0] RST_TAB_SIZE    = 7'd8;
  localparam logic       RST_EXPAND_TABS = 1'b1;
  localparam logic [1:0] RST_CTRL_MODE   = CTRL_DROP;
  localparam logic [7:0] RST_SUBST_CHAR  = 8'd32;

  typedef struct packed {
    logic [6:0] tab_size;
    logic       expand_tabs;
    logic [1:0] ctrl_mode;
    logic [7:0] substitute_char;
  } tln_cfg_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [6:0] repeat_res;
    logic       line_done;
  } tln_res_t;

endpackage

FILE: hdl/tln_in_if.sv
interface tln_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       at_eof;

  modport source (output valid, output in_byte, output at_eof, input ready);
  modport sink (input valid, input in_byte, input at_eof, output ready);
endinterface

FILE: hdl/tln_out_if.sv
interface tln_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [6:0] repeat_res;
  logic       line_done;

  modport source (output valid, output out_char, output repeat_res, output line_done,
                  input ready);
  modport sink (input valid, input out_char, input repeat_res, input line_done,
                output ready);
endinterface

FILE: hdl/tln_step.sv
module tln_step #(
  parameter int BUFFER_BYTES = 512
) (
  input  tln_pkg::tln_cfg_t               cfg,
  input  logic [7:0]                      in_byte,
  input  logic                            at_eof,
  input  logic [$clog2(BUFFER_BYTES)-1:0] column,
  input  logic [6:0]                      tab_phase,
  input  logic                            skip_to_lf,
  output logic                            emit,
  output tln_pkg::tln_res_t               res,
  output logic [$clog2(BUFFER_BYTES)-1:0] column_next,
  output logic [6:0]                      tab_phase_next,
  output logic                            skip_to_lf_next
);

  localparam int COL_W = $clog2(BUFFER_BYTES);
  localparam int CMP_W = (COL_W > 7) ? COL_W : 7;
  localparam logic [COL_W-1:0] LINE_CAP = COL_W'(BUFFER_BYTES - 1);

  logic [6:0]       ts;
  logic [6:0]       ph;
  logic [6:0]       stop_gap;
  logic [6:0]       run_len;
  logic [6:0]       ph_inc;
  logic [COL_W-1:0] room;
  logic [CMP_W-1:0] stop_gap_x;
  logic [CMP_W-1:0] room_x;
  logic             is_ctrl;

  // effective tab stop, phase and room left on the line
  always_comb begin
    if (cfg.tab_size < tln_pkg::TAB_MIN) begin
      ts = tln_pkg::TAB_MIN;
    end else if (cfg.tab_size > tln_pkg::TAB_MAX) begin
      ts = tln_pkg::TAB_MAX;
    end else begin
      ts = cfg.tab_size;
    end
    ph         = (tab_phase < ts) ? tab_phase : 7'd0;
    stop_gap   = ts - ph;
    room       = LINE_CAP - column;
    stop_gap_x = CMP_W'(stop_gap);
    room_x     = CMP_W'(room);
    run_len    = (stop_gap_x < room_x) ? stop_gap : room_x[6:0];
    ph_inc     = ph + 7'd1;
    is_ctrl    = (in_byte < tln_pkg::CH_FIRST_PRINT) || (in_byte == tln_pkg::CH_DEL);
  end

  // one item: decide the result and the new line state
  always_comb begin
    emit            = 1'b0;
    res.out_char    = 8'd0;
    res.repeat_res  = 7'd0;
    res.line_done   = 1'b0;
    column_next     = column;
    tab_phase_next  = tab_phase;
    skip_to_lf_next = skip_to_lf;
    if (skip_to_lf) begin
      // swallowing the rest of a CR line ending
      if (at_eof || (in_byte == tln_pkg::CH_LF)) begin
        skip_to_lf_next = 1'b0;
      end
    end else if (at_eof || (in_byte == tln_pkg::CH_LF) || (in_byte == tln_pkg::CH_CR)) begin
      emit            = 1'b1;
      res.line_done   = 1'b1;
      column_next     = '0;
      tab_phase_next  = 7'd0;
      skip_to_lf_next = !at_eof && (in_byte == tln_pkg::CH_CR);
    end else if ((in_byte == tln_pkg::CH_TAB) && cfg.expand_tabs) begin
      // space run to the next stop, cut at the line capacity
      if (run_len != 7'd0) begin
        emit           = 1'b1;
        res.out_char   = tln_pkg::CH_SPACE;
        res.repeat_res = run_len;
        column_next    = column + COL_W'(run_len);
        tab_phase_next = (run_len == stop_gap) ? 7'd0 : (ph + run_len);
      end
    end else if (column != LINE_CAP) begin
      if (!(is_ctrl && (cfg.ctrl_mode == tln_pkg::CTRL_DROP))) begin
        emit           = 1'b1;
        res.out_char   = (is_ctrl && (cfg.ctrl_mode == tln_pkg::CTRL_REPLACE)) ?
                         cfg.substitute_char : in_byte;
        res.repeat_res = 7'd1;
        column_next    = column + COL_W'(1);
        tab_phase_next = (ph_inc == ts) ? 7'd0 : ph_inc;
      end
    end
  end

endmodule

FILE: hdl/text_line_normalizer_top.sv
// Text line normalizer: takes one byte (or an end-of-file mark) per request on
// rx and returns at most one request on tx: a character with a repeat count
// (a tab expands to a space run up to the next stop, capped at the line
// capacity of BUFFER_BYTES-1 characters), or a line-end marker for LF, CR or
// end of file. Bytes following a CR are swallowed up to and including the
// next LF. Control bytes are kept, replaced or dropped per ctrl_mode. The
// block takes one byte every cycle while tx keeps taking results; a result
// passes through the input register, which holds its byte while the column
// and tab-phase update runs, and then the result register, which drives tx.
// A result stalled on tx holds the next byte in the input register, and rx
// stops accepting once that register is full. Write the config registers only
// while the block is idle.
module text_line_normalizer_top #(
  parameter int BUFFER_BYTES = 512
) (
  input  logic       clk,
  input  logic       rst,
  tln_in_if.sink     rx,
  tln_out_if.source  tx,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [7:0] cfg_data
);

  localparam int COL_W = $clog2(BUFFER_BYTES);

  tln_pkg::tln_cfg_t cfg;
  logic [COL_W-1:0]  column;
  logic [6:0]        tab_phase;
  logic              skip_to_lf;

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              s1_eof;
  logic              out_valid;
  tln_pkg::tln_res_t out_res;

  logic              advance;
  logic              emit;
  tln_pkg::tln_res_t step_res;
  logic [COL_W-1:0]  column_next;
  logic [6:0]        tab_phase_next;
  logic              skip_to_lf_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tab_size        <= tln_pkg::RST_TAB_SIZE;
      cfg.expand_tabs     <= tln_pkg::RST_EXPAND_TABS;
      cfg.ctrl_mode       <= tln_pkg::RST_CTRL_MODE;
      cfg.substitute_char <= tln_pkg::RST_SUBST_CHAR;
    end else if (cfg_we) begin
      case (cfg_idx)
        tln_pkg::REG_TAB_SIZE:    cfg.tab_size        <= cfg_data[6:0];
        tln_pkg::REG_EXPAND_TABS: cfg.expand_tabs     <= cfg_data[0];
        tln_pkg::REG_CTRL_MODE:   cfg.ctrl_mode       <= cfg_data[1:0];
        tln_pkg::REG_SUBST_CHAR:  cfg.substitute_char <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1 moves on when the result register is free or being drained
  assign advance  = s1_valid && (!out_valid || tx.ready);
  assign rx.ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.in_byte;
      s1_eof  <= rx.at_eof;
    end
  end

  tln_step #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_step (
    .cfg            (cfg),
    .in_byte        (s1_byte),
    .at_eof         (s1_eof),
    .column         (column),
    .tab_phase      (tab_phase),
    .skip_to_lf     (skip_to_lf),
    .emit           (emit),
    .res            (step_res),
    .column_next    (column_next),
    .tab_phase_next (tab_phase_next),
    .skip_to_lf_next(skip_to_lf_next)
  );

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      column     <= '0;
      tab_phase  <= 7'd0;
      skip_to_lf <= 1'b0;
    end else if (advance) begin
      column     <= column_next;
      tab_phase  <= tab_phase_next;
      skip_to_lf <= skip_to_lf_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_res <= step_res;
    end
  end

  assign tx.valid      = out_valid;
  assign tx.out_char   = out_res.out_char;
  assign tx.repeat_res = out_res.repeat_res;
  assign tx.line_done  = out_res.line_done;

endmodule

FILE: hdl/tln_checker.sv
`include "text_line_normalizer_top_defines.svh"

module tln_checker (
  input logic       clk,
  input logic       rst,
  input logic       tx_valid,
  input logic       tx_ready,
  input logic [7:0] out_char,
  input logic [6:0] repeat_res,
  input logic       line_done
);

  // a result waiting on the sink keeps its content
  `TLN_ASSERT_NEXT(a_tx_hold, tx_valid && !tx_ready, tx_valid && $stable(out_char) && $stable(repeat_res) && $stable(line_done), "tx request changed while stalled")

  // line-end results carry no character
  `TLN_ASSERT_NOW(a_line_end_empty, tx_valid && line_done, (repeat_res == 7'd0) && (out_char == 8'd0), "line end with a payload")

  // character results carry a run of 1 to 80
  `TLN_ASSERT_NOW(a_run_len, tx_valid && !line_done, (repeat_res != 7'd0) && (repeat_res <= 7'd80), "bad run length")

  // nothing is offered right after reset
  `TLN_ASSERT_ALWAYS_NEXT(a_reset_quiet, rst, !tx_valid, "tx valid right after reset")

endmodule

bind text_line_normalizer_top tln_checker u_tln_checker (
  .clk       (clk),
  .rst       (rst),
  .tx_valid  (tx.valid),
  .tx_ready  (tx.ready),
  .out_char  (tx.out_char),
  .repeat_res(tx.repeat_res),
  .line_done (tx.line_done)
);
